// ----- rtl/core/tpsd_pkg.sv -----
// ----------------------------------------------------------------------------
// tpsd_pkg: shared types and constants of the TGA pixel stream decoder
// Transfer payloads, phase codes, header byte offsets and status codes.
// ----------------------------------------------------------------------------
package tpsd_pkg;

	// one byte of the file stream
	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_of_file;
	} in_t;

	// one decoded pixel or a status report
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       last_pixel;
		logic       status;
	} out_t;

	// decoder phase, one-hot
	typedef enum logic [3:0] {
		PH_HEADER = 4'b0001,
		PH_SKIP   = 4'b0010,
		PH_PIXELS = 4'b0100,
		PH_IDLE   = 4'b1000
	} phase_t;

	localparam int unsigned HDR_BYTES = 18;
	localparam int unsigned HDR_IDX_W = 5;

	// header byte offsets of the fields we use
	localparam logic [HDR_IDX_W-1:0] HI_ID_LEN    = 5'd0;
	localparam logic [HDR_IDX_W-1:0] HI_MAP_TYPE  = 5'd1;
	localparam logic [HDR_IDX_W-1:0] HI_MAP_LEN_L = 5'd5;
	localparam logic [HDR_IDX_W-1:0] HI_MAP_LEN_H = 5'd6;
	localparam logic [HDR_IDX_W-1:0] HI_MAP_BITS  = 5'd7;
	localparam logic [HDR_IDX_W-1:0] HI_WIDTH_L   = 5'd12;
	localparam logic [HDR_IDX_W-1:0] HI_WIDTH_H   = 5'd13;
	localparam logic [HDR_IDX_W-1:0] HI_HEIGHT_L  = 5'd14;
	localparam logic [HDR_IDX_W-1:0] HI_HEIGHT_H  = 5'd15;
	localparam logic [HDR_IDX_W-1:0] HI_DEPTH     = 5'd16;
	localparam logic [HDR_IDX_W-1:0] HI_LAST      = 5'(HDR_BYTES - 1);

	localparam logic [7:0] MAP_PRESENT = 8'd1;
	localparam logic [7:0] DEPTH_24    = 8'd24;
	localparam logic [7:0] DEPTH_32    = 8'd32;
	localparam logic [7:0] OPAQUE      = 8'd255;
	localparam logic [8:0] ROUND_UP    = 9'd7;

	// ID field plus colour map: 255 + 65535 * 32 fits in 22 bits
	localparam int unsigned SKIP_W = 22;
	localparam int unsigned PIX_W  = 32;

	localparam logic ST_PIXEL       = 1'b0;
	localparam logic ST_UNSUPPORTED = 1'b1;

endpackage

// ----- rtl/core/tpsd_decode.sv -----
// ----------------------------------------------------------------------------
// tpsd_decode: byte-level decode state of the TGA pixel stream decoder
// Header capture, ID/colour map skip and pixel packing, one byte per step.
// ----------------------------------------------------------------------------
module tpsd_decode (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  tpsd_pkg::in_t item,
	output logic          res_valid,
	output tpsd_pkg::out_t res
);
	import tpsd_pkg::*;

	phase_t                 phase_q, phase_d;
	logic [HDR_IDX_W-1:0]   hdr_idx_q, hdr_idx_d;
	logic [7:0]             id_len_q, map_type_q, map_bits_q, depth_q;
	logic [15:0]            map_len_q, width_q, height_q;
	logic [SKIP_W-1:0]      skip_total_q, skip_rem_q, skip_rem_d;
	logic [PIX_W-1:0]       pix_total_q, pix_rem_q, pix_rem_d;
	logic [1:0]             bip_q, bip_d;
	logic [23:0]            held_q, held_d;

	phase_t                 phase_cur;
	logic [HDR_IDX_W-1:0]   hdr_idx_cur;
	logic [7:0]             b;
	logic [5:0]             entry_bytes;
	logic [SKIP_W-1:0]      map_bytes;
	logic [2:0]             pix_bytes;
	logic [2:0]             bip_inc;
	logic [23:0]            held_fill;
	logic                   depth_ok;

	assign b = item.data_byte;

	// start of file abandons the current file
	assign phase_cur   = item.start_of_file ? PH_HEADER : phase_q;
	assign hdr_idx_cur = item.start_of_file ? '0 : hdr_idx_q;

	// colour map size, bytes per entry rounded up
	assign entry_bytes = 6'(({1'b0, map_bits_q} + ROUND_UP) >> 3);
	assign map_bytes   = (map_type_q == MAP_PRESENT) ? SKIP_W'(map_len_q * entry_bytes) : '0;

	assign depth_ok  = (depth_q == DEPTH_24) || (depth_q == DEPTH_32);
	assign pix_bytes = (depth_q == DEPTH_32) ? 3'd4 : 3'd3;
	assign bip_inc   = {1'b0, bip_q} + 3'd1;

	// place the byte in the held colour word
	always_comb begin
		held_fill = held_q;
		unique case (bip_q)
			2'd0: held_fill[7:0]   = b;
			2'd1: held_fill[15:8]  = b;
			2'd2: held_fill[23:16] = b;
			default: held_fill = held_q;
		endcase
	end

	// next-state and result logic
	always_comb begin
		phase_d    = phase_q;
		hdr_idx_d  = hdr_idx_q;
		skip_rem_d = skip_rem_q;
		pix_rem_d  = pix_rem_q;
		bip_d      = bip_q;
		held_d     = held_q;
		res_valid  = 1'b0;
		res        = '0;
		if (step) begin
			phase_d   = phase_cur;
			hdr_idx_d = hdr_idx_cur;
			unique case (phase_cur)
				PH_HEADER: begin
					if (hdr_idx_cur == HI_LAST) begin
						hdr_idx_d = '0;
						if (!depth_ok) begin
							phase_d    = PH_IDLE;
							res_valid  = 1'b1;
							res.status = ST_UNSUPPORTED;
						end else if (skip_total_q != '0) begin
							phase_d    = PH_SKIP;
							skip_rem_d = skip_total_q;
						end else begin
							pix_rem_d = pix_total_q;
							bip_d     = '0;
							held_d    = '0;
							phase_d   = (pix_total_q == '0) ? PH_IDLE : PH_PIXELS;
						end
					end else begin
						hdr_idx_d = hdr_idx_cur + 1'b1;
					end
				end
				PH_SKIP: begin
					skip_rem_d = skip_rem_q - 1'b1;
					if (skip_rem_q == SKIP_W'(1)) begin
						pix_rem_d = pix_total_q;
						bip_d     = '0;
						held_d    = '0;
						phase_d   = (pix_total_q == '0) ? PH_IDLE : PH_PIXELS;
					end
				end
				PH_PIXELS: begin
					if (bip_q != 2'd3) begin
						held_d = held_fill;
						bip_d  = bip_inc[1:0];
					end
					if (bip_q == 2'd3 || bip_inc == pix_bytes) begin
						res_valid      = 1'b1;
						res.red        = held_fill[23:16];
						res.green      = held_fill[15:8];
						res.blue       = held_fill[7:0];
						res.alpha      = (bip_q == 2'd3) ? b : OPAQUE;
						res.last_pixel = (pix_rem_q == PIX_W'(1));
						res.status     = ST_PIXEL;
						pix_rem_d      = pix_rem_q - 1'b1;
						bip_d          = '0;
						held_d         = '0;
						if (pix_rem_q == PIX_W'(1))
							phase_d = PH_IDLE;
					end
				end
				PH_IDLE: begin
					phase_d = PH_IDLE;
				end
				default: phase_d = PH_HEADER;
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			hdr_idx_q <= '0;
			bip_q     <= '0;
			held_q    <= '0;
		end else begin
			phase_q   <= phase_d;
			hdr_idx_q <= hdr_idx_d;
			bip_q     <= bip_d;
			held_q    <= held_d;
		end
	end

	// header fields and counters; each is written before it is used
	always_ff @(posedge clk) begin
		skip_rem_q <= skip_rem_d;
		pix_rem_q  <= pix_rem_d;
		if (step && phase_cur == PH_HEADER) begin
			unique case (hdr_idx_cur)
				HI_ID_LEN:    id_len_q        <= b;
				HI_MAP_TYPE:  map_type_q      <= b;
				HI_MAP_LEN_L: map_len_q[7:0]  <= b;
				HI_MAP_LEN_H: map_len_q[15:8] <= b;
				HI_MAP_BITS:  map_bits_q      <= b;
				HI_WIDTH_L:   width_q[7:0]    <= b;
				HI_WIDTH_H:   width_q[15:8]   <= b;
				HI_HEIGHT_L:  height_q[7:0]   <= b;
				HI_HEIGHT_H:  height_q[15:8]  <= b;
				HI_DEPTH: begin
					// geometry is complete here; the products settle before the last byte
					depth_q      <= b;
					pix_total_q  <= PIX_W'(width_q) * PIX_W'(height_q);
					skip_total_q <= SKIP_W'(id_len_q) + map_bytes;
				end
				default: ;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_status_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status == ST_UNSUPPORTED |=> phase_q == PH_IDLE)
		else $error("unsupported depth did not end the file");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.last_pixel |=> phase_q == PH_IDLE)
		else $error("last pixel did not end the file");
	a_hdr_range: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_idx_q <= HI_LAST)
		else $error("header index out of range");
	a_skip_live: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SKIP |-> skip_rem_q != '0)
		else $error("skip phase with nothing to skip");
`endif

endmodule

// ----- rtl/core/tga_pixel_stream_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// tga_pixel_stream_decoder_unit: uncompressed true-colour TGA decoder
// Takes a TGA file byte by byte and returns RGBA pixels or a status report.
// ----------------------------------------------------------------------------
// One file byte is taken per clock cycle, sustained, while the pixel side
// keeps up; a byte passes an input register and the decode step, and its
// pixel (if any) is then held in the output register. The rate is set by
// the single decode step, which holds the header, skip and pixel counters.
// Header bytes 0-17 are captured, the ID field and any colour map are
// skipped, then each B,G,R (24-bit) or B,G,R,A (32-bit) group yields one
// pixel; the final pixel carries last_pixel. Any other depth yields a single
// result with status set on header byte 17. start_of_file restarts decoding
// at any point.
module tga_pixel_stream_decoder_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           byte_valid,
	output logic           byte_ready,
	input  tpsd_pkg::in_t  byte_data,
	output logic           pixel_valid,
	input  logic           pixel_ready,
	output tpsd_pkg::out_t pixel_data
);
	import tpsd_pkg::*;

	logic  s1_valid_q;
	in_t   item_s1;
	logic  out_valid_q;
	out_t  out_q;
	logic  advance;
	logic  res_valid;
	out_t  res;

	// the stage moves on whenever the output register is free or being emptied
	assign advance    = !out_valid_q || pixel_ready;
	assign byte_ready = !s1_valid_q || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (byte_ready) begin
			s1_valid_q <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready)
			item_s1 <= byte_data;
	end

	tpsd_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (s1_valid_q && advance),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= s1_valid_q && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && s1_valid_q && res_valid)
			out_q <= res;
	end

	assign pixel_valid = out_valid_q;
	assign pixel_data  = out_q;

`ifndef NO_ASSERTIONS
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!byte_ready |-> s1_valid_q && out_valid_q && !pixel_ready)
		else $error("input stalled without a blocked result");
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(s1_valid_q))
		else $error("result appeared without a byte in the stage");
	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !advance |=> s1_valid_q && $stable(item_s1))
		else $error("stalled byte lost or changed");
`endif

endmodule
